// ===== rtl/lwbsc_pkg.sv =====
// Shared types and codes for the sector cache tag controller.
`default_nettype none
package lwbsc_pkg;

    typedef enum logic [1:0] {
        CMD_READ   = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_FLUSH  = 2'd2,
        CMD_UNUSED = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ACT_WRITEBACK = 2'd0,
        ACT_FILL      = 2'd1,
        ACT_SERVED    = 2'd2,
        ACT_NOTHING   = 2'd3
    } action_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_SCMP,
        ST_WRD,
        ST_WEMIT,
        ST_FILL,
        ST_SERVE,
        ST_FSCAN,
        ST_FEMIT,
        ST_NOTHING
    } state_t;

    typedef enum logic [1:0] {
        LRU_INIT,
        LRU_IDLE,
        LRU_OLD,
        LRU_SWEEP
    } lru_state_t;

endpackage
`default_nettype wire

// ===== rtl/lru_write_back_sector_cache_core.sv =====
// Top level of the fully associative write-back sector cache tag controller.
`default_nettype none
// The block keeps the sector tag of each slot in a synchronous RAM and the
// valid and dirty marks in flip-flops, with an LRU rank RAM beside them.
// A read or write request (tuser 0 or 1) sweeps the tag RAM from slot 0 and
// stops at the first valid slot holding the sector; each slot examined takes
// a read state and a compare state, set by the single read port of the tag
// RAM. A miss replaces the least recent slot: a writeback result for its old
// sector comes first if it is dirty, then a fill result, and every access ends
// with a served result (tlast high). Once the served result is loaded, the
// rank RAM is rewritten by a sweep over all slots, and s_tready stays low
// until the sweep is done. A flush request (tuser 2) visits the slots in
// order, with a scan state per slot and an emit state for each dirty slot, and
// gives one writeback per dirty slot, or a single nothing-to-flush result.
// Each result is held in the output register until it is taken; a new request
// is taken while the last result still waits there. Command 3 is dropped. No
// clearing pass runs on the tags after reset: tags are read only for valid
// slots. The rank RAM is loaded with slot i at rank i by an init pass after
// reset, and s_tready stays low until that is done.
module lru_write_back_sector_cache_core
    import lwbsc_pkg::*;
#(
    parameter int SLOTS       = 64,
    parameter int SECTOR_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // [31:0] sector
    input  wire logic [31:0] s_tdata,
    // [1:0] cmd
    input  wire logic [1:0] s_tuser,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // [SLOT_W-1:0] slot, then target_sector, zero padded to whole bytes
    output logic [((($clog2(SLOTS) + SECTOR_BITS) + 7) / 8) * 8 - 1:0] m_tdata,
    // [1:0] action
    output logic [1:0] m_tuser,
    output logic       m_tlast
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int OUT_W  = (((SLOT_W + SECTOR_BITS) + 7) / 8) * 8;

    state_t state_reg, state_next;

    logic [SLOT_W-1:0]      idx_reg, idx_next;
    logic [SLOT_W-1:0]      victim_reg, victim_next;
    logic [SECTOR_BITS-1:0] sec_reg;
    logic                   wr_reg;
    logic [SLOTS-1:0]       valid_reg, valid_next;
    logic [SLOTS-1:0]       dirty_reg, dirty_next;

    logic                   out_valid_reg;
    action_t                out_action_reg;
    logic [SLOT_W-1:0]      out_slot_reg;
    logic [SECTOR_BITS-1:0] out_target_reg;
    logic                   out_last_reg;

    logic                   emit;
    action_t                emit_action;
    logic [SECTOR_BITS-1:0] emit_target;
    logic                   emit_last;
    logic                   out_free;
    logic                   load;

    logic                   accept;
    logic                   tag_we;
    logic [SECTOR_BITS-1:0] tag_rdata;
    logic                   touch;
    logic                   rd_oldest;
    logic                   lru_busy;
    logic [SLOTS-1:0]       above_mask;
    logic                   is_last_slot;
    logic                   hit_now;

    lwbsc_ram #(
        .WIDTH (SECTOR_BITS),
        .DEPTH (SLOTS)
    ) u_tags (
        .clk   (clk),
        .we    (tag_we),
        .waddr (idx_reg),
        .wdata (sec_reg),
        .raddr (idx_reg),
        .rdata (tag_rdata)
    );

    lwbsc_lru #(
        .SLOTS (SLOTS)
    ) u_lru (
        .clk        (clk),
        .rst_n      (rst_n),
        .touch      (touch),
        .touch_slot (idx_reg),
        .rd_slot    (idx_reg),
        .rd_oldest  (rd_oldest),
        .busy       (lru_busy)
    );

    assign s_tready = (state_reg == ST_IDLE) && !lru_busy;
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign load     = emit && out_free;

    assign is_last_slot = (idx_reg == SLOT_W'(SLOTS - 1));
    assign hit_now      = valid_reg[idx_reg] && (tag_rdata == sec_reg);

    // Slots above the current flush index, used to mark the final writeback.
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            above_mask[i] = (SLOT_W'(i) > idx_reg);
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        victim_next = victim_reg;
        valid_next  = valid_reg;
        dirty_next  = dirty_reg;
        emit        = 1'b0;
        emit_action = ACT_SERVED;
        emit_target = sec_reg;
        emit_last   = 1'b0;
        tag_we      = 1'b0;
        touch       = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    idx_next = '0;
                    case (cmd_t'(s_tuser))
                        CMD_READ, CMD_WRITE: state_next = ST_SRD;
                        CMD_FLUSH:
                        begin
                            state_next = (dirty_reg == '0) ? ST_NOTHING : ST_FSCAN;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end

            ST_SRD:
            begin
                state_next = ST_SCMP;
            end

            ST_SCMP:
            begin
                if (rd_oldest)
                begin
                    victim_next = idx_reg;
                end
                if (hit_now)
                begin
                    state_next = ST_SERVE;
                end
                else if (is_last_slot)
                begin
                    // Miss: the slot of rank zero is replaced.
                    idx_next = rd_oldest ? idx_reg : victim_reg;
                    if (valid_reg[idx_next] && dirty_reg[idx_next])
                    begin
                        state_next = ST_WRD;
                    end
                    else
                    begin
                        state_next = ST_FILL;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRD;
                end
            end

            ST_WRD:
            begin
                state_next = ST_WEMIT;
            end

            ST_WEMIT:
            begin
                emit        = 1'b1;
                emit_action = ACT_WRITEBACK;
                emit_target = tag_rdata;
                if (out_free)
                begin
                    dirty_next[idx_reg] = 1'b0;
                    state_next          = ST_FILL;
                end
            end

            ST_FILL:
            begin
                emit        = 1'b1;
                emit_action = ACT_FILL;
                if (out_free)
                begin
                    tag_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    dirty_next[idx_reg] = 1'b0;
                    state_next          = ST_SERVE;
                end
            end

            ST_SERVE:
            begin
                emit        = 1'b1;
                emit_action = ACT_SERVED;
                emit_last   = 1'b1;
                if (out_free)
                begin
                    touch = 1'b1;
                    if (wr_reg)
                    begin
                        dirty_next[idx_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FSCAN:
            begin
                // The tag of the current slot is presented now and read next cycle.
                if (dirty_reg[idx_reg])
                begin
                    state_next = ST_FEMIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            ST_FEMIT:
            begin
                emit        = 1'b1;
                emit_action = ACT_WRITEBACK;
                emit_target = tag_rdata;
                emit_last   = ((dirty_reg & above_mask) == '0);
                if (out_free)
                begin
                    dirty_next[idx_reg] = 1'b0;
                    if (emit_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_FSCAN;
                    end
                end
            end

            ST_NOTHING:
            begin
                emit        = 1'b1;
                emit_action = ACT_NOTHING;
                emit_target = '0;
                emit_last   = 1'b1;
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            victim_reg    <= '0;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            idx_reg    <= idx_next;
            victim_reg <= victim_next;
            valid_reg  <= valid_next;
            dirty_reg  <= dirty_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sec_reg <= SECTOR_BITS'(s_tdata);
            wr_reg  <= (cmd_t'(s_tuser) == CMD_WRITE);
        end
        if (load)
        begin
            out_action_reg <= emit_action;
            out_slot_reg   <= (emit_action == ACT_NOTHING) ? '0 : idx_reg;
            out_target_reg <= emit_target;
            out_last_reg   <= emit_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_action_reg;
    assign m_tdata  = OUT_W'({out_target_reg, out_slot_reg});
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ===== rtl/lwbsc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module lwbsc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/lwbsc_lru.sv =====
// LRU rank table: one rank per slot in a RAM, rewritten by a sweep after each touch.
`default_nettype none
module lwbsc_lru
    import lwbsc_pkg::*;
#(
    parameter int SLOTS = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     touch,
    input  wire logic [$clog2(SLOTS)-1:0] touch_slot,
    input  wire logic [$clog2(SLOTS)-1:0] rd_slot,
    output logic                          rd_oldest,
    output logic                          busy
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    lru_state_t state_reg, state_next;

    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SLOT_W-1:0] old_reg, old_next;
    logic              rank_we;
    logic [SLOT_W-1:0] rank_wdata;
    logic [SLOT_W-1:0] rank_raddr;
    logic [SLOT_W-1:0] rank_rdata;

    lwbsc_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (SLOTS)
    ) u_ranks (
        .clk   (clk),
        .we    (rank_we),
        .waddr (ptr_reg),
        .wdata (rank_wdata),
        .raddr (rank_raddr),
        .rdata (rank_rdata)
    );

    assign busy      = (state_reg != LRU_IDLE);
    assign rd_oldest = (rank_rdata == '0);

    // After reset the ranks are loaded with slot i at rank i. A touch first
    // fetches the touched slot's rank, then sweeps every slot once: slots ranked
    // above it move down by one and the touched slot takes the top rank. The
    // sweep reads slot p+1 while it writes slot p.
    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        slot_next  = slot_reg;
        old_next   = old_reg;
        rank_we    = 1'b0;
        rank_wdata = '0;
        rank_raddr = rd_slot;

        case (state_reg)
            LRU_INIT:
            begin
                rank_we    = 1'b1;
                rank_wdata = ptr_reg;
                if (ptr_reg == LAST_SLOT)
                begin
                    ptr_next   = '0;
                    state_next = LRU_IDLE;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end

            LRU_IDLE:
            begin
                if (touch)
                begin
                    rank_raddr = touch_slot;
                    slot_next  = touch_slot;
                    state_next = LRU_OLD;
                end
            end

            LRU_OLD:
            begin
                old_next   = rank_rdata;
                rank_raddr = '0;
                ptr_next   = '0;
                state_next = LRU_SWEEP;
            end

            LRU_SWEEP:
            begin
                if (ptr_reg == slot_reg)
                begin
                    rank_we    = 1'b1;
                    rank_wdata = LAST_SLOT;
                end
                else if (rank_rdata > old_reg)
                begin
                    rank_we    = 1'b1;
                    rank_wdata = rank_rdata - 1'b1;
                end
                if (ptr_reg == LAST_SLOT)
                begin
                    ptr_next   = '0;
                    state_next = LRU_IDLE;
                end
                else
                begin
                    ptr_next   = ptr_reg + 1'b1;
                    rank_raddr = ptr_reg + 1'b1;
                end
            end

            default:
            begin
                state_next = LRU_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LRU_INIT;
            ptr_reg   <= '0;
            slot_reg  <= '0;
            old_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            ptr_reg   <= ptr_next;
            slot_reg  <= slot_next;
            old_reg   <= old_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking testbench for the LRU write-back sector cache tag controller.
`default_nettype none

// Tracks the cache state and holds the results each accepted request should cause.
class sector_cache_scoreboard;
    typedef struct packed {
        lwbsc_pkg::action_t action;
        logic [5:0]         slot;
        logic [31:0]        target;
        logic               last;
    } cache_result_t;

    logic [31:0]   tags [64];
    bit            valid [64];
    bit            dirty [64];
    int unsigned   rank [64];
    cache_result_t pending [$];
    int            errors;

    function new();
        errors = 0;
        for (int i = 0; i < 64; i++)
        begin
            tags[i] = '0;
            valid[i] = 0;
            dirty[i] = 0;
            rank[i] = i;
        end
    endfunction

    function void push(lwbsc_pkg::action_t a, int s, logic [31:0] t, bit l);
        cache_result_t r;
        r.action = a;
        r.slot = s[5:0];
        r.target = t;
        r.last = l;
        pending.push_back(r);
    endfunction

    // Works out the results of one accepted request and updates the state.
    function void note_request(lwbsc_pkg::cmd_t cmd, logic [31:0] sector);
        int n;
        int slot;
        bit hit;
        int old;
        n = 0;
        slot = 0;
        hit = 0;
        if (cmd == lwbsc_pkg::CMD_UNUSED)
            return;
        if (cmd == lwbsc_pkg::CMD_FLUSH)
        begin
            for (int i = 0; i < 64; i++)
                if (dirty[i])
                begin
                    push(lwbsc_pkg::ACT_WRITEBACK, i, tags[i], 0);
                    dirty[i] = 0;
                    n++;
                end
            if (n == 0)
                push(lwbsc_pkg::ACT_NOTHING, 0, '0, 1);
            else
                pending[$].last = 1;
            return;
        end
        for (int i = 0; i < 64; i++)
            if (!hit && valid[i] && tags[i] == sector)
            begin
                slot = i;
                hit = 1;
            end
        if (!hit)
        begin
            for (int i = 0; i < 64; i++)
                if (rank[i] == 0)
                    slot = i;
            if (valid[slot] && dirty[slot])
                push(lwbsc_pkg::ACT_WRITEBACK, slot, tags[slot], 0);
            tags[slot] = sector;
            valid[slot] = 1;
            dirty[slot] = 0;
            push(lwbsc_pkg::ACT_FILL, slot, sector, 0);
        end
        // The touched slot becomes most recent; those above it move down.
        old = rank[slot];
        for (int i = 0; i < 64; i++)
            if (rank[i] > old)
                rank[i]--;
        rank[slot] = 63;
        if (cmd == lwbsc_pkg::CMD_WRITE)
            dirty[slot] = 1;
        push(lwbsc_pkg::ACT_SERVED, slot, sector, 1);
    endfunction

    // Compares one accepted result with the oldest expectation.
    function void check_result(logic [1:0] a, logic [5:0] s, logic [31:0] t, logic l);
        cache_result_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected result: action %0d slot %0d sector %h", a, s, t);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (a !== e.action)
        begin
            $error("action: expected %0d, actual %0d", e.action, a);
            errors++;
        end
        if (s !== e.slot)
        begin
            $error("slot: expected %0d, actual %0d", e.slot, s);
            errors++;
        end
        if (t !== e.target)
        begin
            $error("target_sector: expected %h, actual %h", e.target, t);
            errors++;
        end
        if (l !== e.last)
        begin
            $error("last: expected %0d, actual %0d", e.last, l);
            errors++;
        end
    endfunction
endclass

module tb;
    import lwbsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    // Once set, both sides stop idling for the last part of the run.
    bit no_idle = 0;
    sector_cache_scoreboard sb = new();

    // A small pool of sectors keeps hits, evictions and dirty writebacks frequent.
    logic [31:0] pool [16];

    always #5 clk = ~clk;

    lru_write_back_sector_cache_core DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast)
    );

    // Sends one request and waits for its handshake, with an optional idle gap first.
    // Valid stays high between back-to-back requests and drops only for a gap.
    task automatic send_request(cmd_t cmd, logic [31:0] sector);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser <= cmd;
        s_tdata <= sector;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_request(cmd, sector);
    endtask

    // Picks a sector: mostly from the pool so that the cache fills and evicts.
    function automatic logic [31:0] pick_sector();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return pool[$urandom_range(0, 15)];
        else if (r < 9)
            return $urandom_range(0, 80);
        return $urandom();
    endfunction

    // The receiver checks every accepted result on the edge where it is taken.
    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata[5:0], m_tdata[37:6], m_tlast);

    // The receiver stalls in random bursts until the last part of the run.
    initial
    begin
        int stall;
        stall = 0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
                m_tready <= 1;
            else if (stall > 0)
            begin
                stall--;
                m_tready <= 0;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 8) - 1;
                m_tready <= 0;
            end
            else
                m_tready <= 1;
        end
    end

    initial
    begin
        cmd_t c;
        for (int i = 0; i < 16; i++)
            pool[i] = $urandom();
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part: empty flush, field extremes, hits, dirty flush, unused command.
        send_request(CMD_FLUSH, 32'h0);
        send_request(CMD_READ, 32'h0);
        send_request(CMD_READ, 32'hFFFF_FFFF);
        send_request(CMD_WRITE, 32'hFFFF_FFFF);
        send_request(CMD_WRITE, 32'hAAAA_5555);
        send_request(CMD_READ, 32'h0);
        send_request(CMD_UNUSED, 32'h1234_5678);
        send_request(CMD_FLUSH, 32'hFFFF_FFFF);
        send_request(CMD_FLUSH, 32'h0);
        send_request(CMD_WRITE, 32'h5555_AAAA);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF);
        // Fill all slots with written sectors so that misses evict dirty victims.
        for (int i = 0; i < 66; i++)
            send_request(CMD_WRITE, 32'h100 + i);
        send_request(CMD_FLUSH, 32'h0);

        // Random part.
        for (int i = 0; i < 220; i++)
        begin
            int r;
            if (i == 170)
                no_idle = 1;
            r = $urandom_range(0, 19);
            if (r < 9)
                c = CMD_READ;
            else if (r < 17)
                c = CMD_WRITE;
            else if (r < 19)
                c = CMD_FLUSH;
            else
                c = CMD_UNUSED;
            send_request(c, pick_sector());
        end
        s_tvalid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("** lru_write_back_sector_cache_core: PASSED **");
        else
            $display("** lru_write_back_sector_cache_core: FAILED **");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #20ms;
        $display("** lru_write_back_sector_cache_core: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
